@@ rtl/accel_tilt_angle_unit_defines.svh @@
// ---------------------------------------------------------------------------
// accel_tilt_angle_unit_defines.svh
// Assertion macros for the tilt angle unit.
// ---------------------------------------------------------------------------
`ifndef ACCEL_TILT_ANGLE_UNIT_DEFINES_SVH
`define ACCEL_TILT_ANGLE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled in reset
`define ATA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled in reset
`define ATA_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ATA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define ATA_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

@@ rtl/ata_pkg.sv @@
// ---------------------------------------------------------------------------
// ata_pkg
// Types, widths and constants shared by the tilt angle unit and its cells.
// ---------------------------------------------------------------------------
`default_nettype none

package ata_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int TILT_W          = 16;
    // output fraction bits, 8..20
    localparam int ANGLE_FRAC_BITS = 14;
    localparam int CORDIC_STAGES   = 16;

    localparam int ACC_FRAC    = 30;
    localparam int TABLE_LEN   = 24;
    localparam int ROUND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int ROUND_W     = 38;

    // square root of {sumsq, 32 zero bits}: two radicand bits per step
    localparam int SQRT_STEPS = 32;
    localparam int ROOT_W     = 32;
    localparam int REM_W      = 34;
    localparam int RAD_W      = 64;
    localparam int SUM_W      = 32;
    localparam int SQ_W       = 31;

    localparam int VEC_W = 36;
    localparam int ANG_W = 34;

    localparam logic [31:0] PI_ACC      = 32'd3373259426;
    localparam logic [31:0] HALF_PI_ACC = 32'd1686629713;

    // atan(2^-i), 30 fraction bits
    localparam logic [29:0] ATAN_TAB [TABLE_LEN] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127
    };

    localparam logic [ROUND_W-1:0] PI_TILT_FULL =
        (ROUND_W'(PI_ACC) + (ROUND_W'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
    localparam logic PI_FITS = (PI_TILT_FULL < (ROUND_W'(1) << TILT_W));

    typedef struct packed {
        logic [REM_W-1:0]           rem;
        logic [ROOT_W-1:0]          root;
        logic [RAD_W-1:0]           rad;
        logic signed [SAMPLE_W-1:0] z;
        logic                       zero_h;
    } sqrt_beat_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] vx;
        logic signed [VEC_W-1:0] vy;
        logic signed [ANG_W-1:0] ang;
        logic                    zero_h;
        logic                    z_neg;
    } cordic_beat_t;

endpackage

`default_nettype wire

@@ rtl/ata_sqrt_cell.sv @@
// ---------------------------------------------------------------------------
// ata_sqrt_cell
// One step of the digit-by-digit square root: one root bit per cell.
// ---------------------------------------------------------------------------
`default_nettype none

module ata_sqrt_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                prev_valid,
    input  wire ata_pkg::sqrt_beat_t prev_beat,
    output logic                     valid,
    output ata_pkg::sqrt_beat_t      beat
);

    logic                       valid_reg;
    logic                       valid_next;
    ata_pkg::sqrt_beat_t        beat_reg;
    ata_pkg::sqrt_beat_t        beat_next;
    logic [ata_pkg::REM_W+1:0]  cur;
    logic [ata_pkg::REM_W+1:0]  trial;
    logic                       ge;

    always_comb
    begin
        cur   = {prev_beat.rem, prev_beat.rad[ata_pkg::RAD_W-1 -: 2]};
        trial = (ata_pkg::REM_W + 2)'({prev_beat.root, 2'b01});
        ge    = (cur >= trial);

        beat_next        = prev_beat;
        beat_next.rem    = ge ? ata_pkg::REM_W'(cur - trial) : ata_pkg::REM_W'(cur);
        beat_next.root   = {prev_beat.root[ata_pkg::ROOT_W-2:0], ge};
        beat_next.rad    = prev_beat.rad << 2;
        valid_next       = en ? prev_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            beat_reg <= beat_next;
        end
    end

    assign valid = valid_reg;
    assign beat  = beat_reg;

endmodule

`default_nettype wire

@@ rtl/ata_cordic_cell.sv @@
// ---------------------------------------------------------------------------
// ata_cordic_cell
// One vectoring micro-rotation; SHIFT sets the step and its arctangent.
// ---------------------------------------------------------------------------
`default_nettype none

module ata_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  prev_valid,
    input  wire ata_pkg::cordic_beat_t prev_beat,
    output logic                       valid,
    output ata_pkg::cordic_beat_t      beat
);

    localparam logic signed [ata_pkg::ANG_W-1:0] STEP_ANGLE =
        ata_pkg::ANG_W'(ata_pkg::ATAN_TAB[SHIFT]);

    logic                               valid_reg;
    logic                               valid_next;
    ata_pkg::cordic_beat_t              beat_reg;
    ata_pkg::cordic_beat_t              beat_next;
    logic signed [ata_pkg::VEC_W-1:0]   dx;
    logic signed [ata_pkg::VEC_W-1:0]   dy;
    logic                               vy_pos;

    always_comb
    begin
        dx     = prev_beat.vy >>> SHIFT;
        dy     = prev_beat.vx >>> SHIFT;
        vy_pos = !prev_beat.vy[ata_pkg::VEC_W-1] && (prev_beat.vy != '0);

        beat_next = prev_beat;
        if (vy_pos)
        begin
            beat_next.vx  = prev_beat.vx + dx;
            beat_next.vy  = prev_beat.vy - dy;
            beat_next.ang = prev_beat.ang + STEP_ANGLE;
        end
        else
        begin
            beat_next.vx  = prev_beat.vx - dx;
            beat_next.vy  = prev_beat.vy + dy;
            beat_next.ang = prev_beat.ang - STEP_ANGLE;
        end
        valid_next = en ? prev_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            beat_reg <= beat_next;
        end
    end

    assign valid = valid_reg;
    assign beat  = beat_reg;

endmodule

`default_nettype wire

@@ rtl/accel_tilt_angle_unit.sv @@
// ---------------------------------------------------------------------------
// accel_tilt_angle_unit
// Tilt from vertical, atan2(sqrt(x^2+y^2), z), of one accelerometer sample.
//
//   channel  direction  handshake                   payload
//   sample   in         sample_valid/sample_stall   accel_x, accel_y, accel_z
//   angle    out        angle_valid/angle_stall     tilt
//
// One sample per cycle while sample_stall is low. The registers in order:
// squares, sum, 32 square-root cells, pre-rotation, the CORDIC cells
// (min(CORDIC_STAGES, 24) of them) and the output register.
// Reset clears the valid bits only; there is no carried state.
// A stalled output beat is caught in a one-beat skid; sample_stall is
// high exactly while the skid holds a beat, and the whole row holds then.
// ---------------------------------------------------------------------------
`default_nettype none

`include "accel_tilt_angle_unit_defines.svh"

module accel_tilt_angle_unit #(
    parameter int CORDIC_STAGES = ata_pkg::CORDIC_STAGES
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  sample_valid,
    output logic                                       sample_stall,
    input  wire logic signed [ata_pkg::SAMPLE_W-1:0]   accel_x,
    input  wire logic signed [ata_pkg::SAMPLE_W-1:0]   accel_y,
    input  wire logic signed [ata_pkg::SAMPLE_W-1:0]   accel_z,
    output logic                                       angle_valid,
    input  wire logic                                  angle_stall,
    output logic [ata_pkg::TILT_W-1:0]                 tilt
);

    localparam int STAGES_USED = (CORDIC_STAGES < ata_pkg::TABLE_LEN) ?
                                 CORDIC_STAGES : ata_pkg::TABLE_LEN;

    logic adv;
    logic push;
    logic out_fire;

    // squares
    logic signed [31:0]            prod_x;
    logic signed [31:0]            prod_y;
    logic                          a_valid_reg;
    logic                          a_valid_next;
    logic [ata_pkg::SQ_W-1:0]      x2_reg;
    logic [ata_pkg::SQ_W-1:0]      y2_reg;
    logic signed [ata_pkg::SAMPLE_W-1:0] az_reg;

    // square root row
    logic                          sq0_valid_reg;
    logic                          sq0_valid_next;
    ata_pkg::sqrt_beat_t           sq0_reg;
    ata_pkg::sqrt_beat_t           sq0_next;
    logic [ata_pkg::SUM_W-1:0]     sumsq;
    logic                          sq_valid [ata_pkg::SQRT_STEPS+1];
    ata_pkg::sqrt_beat_t           sq_beat  [ata_pkg::SQRT_STEPS+1];

    // CORDIC row
    logic                          cd0_valid_reg;
    logic                          cd0_valid_next;
    ata_pkg::cordic_beat_t         cd0_reg;
    ata_pkg::cordic_beat_t         cd0_next;
    logic signed [ata_pkg::VEC_W-1:0] vx_z;
    logic signed [ata_pkg::VEC_W-1:0] vy_r;
    logic                          cd_valid [STAGES_USED+1];
    ata_pkg::cordic_beat_t         cd_beat  [STAGES_USED+1];

    // clamp and round
    ata_pkg::cordic_beat_t         last;
    logic [31:0]                   ang_abs;
    logic [ata_pkg::ROUND_W-1:0]   rounded;
    logic [ata_pkg::TILT_W-1:0]    round_angle;

    // output register and skid
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [ata_pkg::TILT_W-1:0]    out_angle_reg;
    logic [ata_pkg::TILT_W-1:0]    out_angle_next;
    logic                          skid_valid_reg;
    logic                          skid_valid_next;
    logic [ata_pkg::TILT_W-1:0]    skid_angle_reg;
    logic [ata_pkg::TILT_W-1:0]    skid_angle_next;

    assign adv          = !skid_valid_reg;
    assign sample_stall = skid_valid_reg;

    // ---- squares --------------------------------------------------------
    assign prod_x       = 32'(accel_x) * 32'(accel_x);
    assign prod_y       = 32'(accel_y) * 32'(accel_y);
    assign a_valid_next = adv ? sample_valid : a_valid_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x2_reg <= prod_x[ata_pkg::SQ_W-1:0];
            y2_reg <= prod_y[ata_pkg::SQ_W-1:0];
            az_reg <= accel_z;
        end
    end

    // ---- sum of squares, root row entry ---------------------------------
    always_comb
    begin
        sumsq           = ata_pkg::SUM_W'(x2_reg) + ata_pkg::SUM_W'(y2_reg);
        sq0_next.rem    = '0;
        sq0_next.root   = '0;
        sq0_next.rad    = {sumsq, {(ata_pkg::RAD_W - ata_pkg::SUM_W){1'b0}}};
        sq0_next.z      = az_reg;
        sq0_next.zero_h = (sumsq == '0);
        sq0_valid_next  = adv ? a_valid_reg : sq0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq0_reg <= sq0_next;
        end
    end

    assign sq_valid[0] = sq0_valid_reg;
    assign sq_beat[0]  = sq0_reg;

    for (genvar i = 0; i < ata_pkg::SQRT_STEPS; i++)
    begin : g_sqrt
        ata_sqrt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (adv),
            .prev_valid (sq_valid[i]),
            .prev_beat  (sq_beat[i]),
            .valid      (sq_valid[i+1]),
            .beat       (sq_beat[i+1])
        );
    end

    // ---- pre-rotation into the right half plane -------------------------
    always_comb
    begin
        vx_z = {{(ata_pkg::VEC_W - ata_pkg::SAMPLE_W - 16)
                    {sq_beat[ata_pkg::SQRT_STEPS].z[ata_pkg::SAMPLE_W-1]}},
                sq_beat[ata_pkg::SQRT_STEPS].z, 16'b0};
        vy_r = ata_pkg::VEC_W'(sq_beat[ata_pkg::SQRT_STEPS].root);
        cd0_next.zero_h = sq_beat[ata_pkg::SQRT_STEPS].zero_h;
        cd0_next.z_neg  = sq_beat[ata_pkg::SQRT_STEPS].z[ata_pkg::SAMPLE_W-1];
        if (cd0_next.z_neg)
        begin
            cd0_next.vx  = vy_r;
            cd0_next.vy  = -vx_z;
            cd0_next.ang = ata_pkg::ANG_W'(ata_pkg::HALF_PI_ACC);
        end
        else
        begin
            cd0_next.vx  = vx_z;
            cd0_next.vy  = vy_r;
            cd0_next.ang = '0;
        end
        cd0_valid_next = adv ? sq_valid[ata_pkg::SQRT_STEPS] : cd0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cd0_reg <= cd0_next;
        end
    end

    assign cd_valid[0] = cd0_valid_reg;
    assign cd_beat[0]  = cd0_reg;

    for (genvar i = 0; i < STAGES_USED; i++)
    begin : g_cordic
        ata_cordic_cell #(
            .SHIFT (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (adv),
            .prev_valid (cd_valid[i]),
            .prev_beat  (cd_beat[i]),
            .valid      (cd_valid[i+1]),
            .beat       (cd_beat[i+1])
        );
    end

    // ---- clamp to 0..pi, round ------------------------------------------
    always_comb
    begin
        last = cd_beat[STAGES_USED];
        if (last.zero_h)
        begin
            ang_abs = last.z_neg ? ata_pkg::PI_ACC : '0;
        end
        else if (last.ang[ata_pkg::ANG_W-1])
        begin
            ang_abs = '0;
        end
        else if (last.ang[ata_pkg::ANG_W-2:0] > (ata_pkg::ANG_W-1)'(ata_pkg::PI_ACC))
        begin
            ang_abs = ata_pkg::PI_ACC;
        end
        else
        begin
            ang_abs = last.ang[31:0];
        end
        rounded     = ata_pkg::ROUND_W'(ang_abs)
                    + (ata_pkg::ROUND_W'(1) << (ata_pkg::ROUND_SHIFT - 1));
        round_angle = rounded[ata_pkg::ROUND_SHIFT +: ata_pkg::TILT_W];
    end

    // ---- output register with skid --------------------------------------
    assign push     = adv && cd_valid[STAGES_USED];
    assign out_fire = out_valid_reg && !angle_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_angle_next  = out_angle_reg;
        skid_valid_next = skid_valid_reg;
        skid_angle_next = skid_angle_reg;
        if (push)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_next = 1'b1;
                out_angle_next = round_angle;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_angle_next = round_angle;
            end
        end
        else if (out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_angle_next  = skid_angle_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            sq0_valid_reg  <= 1'b0;
            cd0_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg    <= a_valid_next;
            sq0_valid_reg  <= sq0_valid_next;
            cd0_valid_reg  <= cd0_valid_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_angle_reg  <= out_angle_next;
        skid_angle_reg <= skid_angle_next;
    end

    assign angle_valid = out_valid_reg;
    assign tilt        = out_angle_reg;

    // ---- assertions -----------------------------------------------------
    `ATA_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg,
        "skid beat with empty output register")
    `ATA_ASSERT_NXT(a_skid_catch, clk, rst_n, push && out_valid_reg && angle_stall,
        skid_valid_reg && (skid_angle_reg == $past(round_angle)),
        "stalled beat not caught in skid")
    `ATA_ASSERT_IMP(a_angle_range, clk, rst_n, out_valid_reg,
        !ata_pkg::PI_FITS || (ata_pkg::ROUND_W'(tilt) <= ata_pkg::PI_TILT_FULL),
        "tilt angle above pi")

endmodule

`default_nettype wire
